/* rtl/sdspi_pkg.sv */
// Shared types, codes and frame helpers for the SD SPI command engine.
`timescale 1ns / 1ps

package sdspi_pkg;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PRE_FF  = 3'd1,
      PH_FRAME   = 3'd2,
      PH_POLL    = 3'd3,
      PH_POST_FF = 3'd4
   } phase_type;

   localparam logic       MODE_START = 1'b0;
   localparam logic       MODE_RX    = 1'b1;
   localparam logic       KIND_TX    = 1'b0;
   localparam logic       KIND_DONE  = 1'b1;

   localparam logic [5:0] APP_PREFIX_INDEX = 6'd55;
   localparam logic [5:0] CMD0_INDEX       = 6'd0;
   localparam logic [5:0] CMD8_INDEX       = 6'd8;
   localparam logic [7:0] CRC_CMD0         = 8'h95;
   localparam logic [7:0] CRC_CMD8         = 8'h87;
   localparam logic [7:0] CRC_OTHER        = 8'h01;
   localparam logic [7:0] START_BITS       = 8'h40;
   localparam logic [7:0] FILL_BYTE        = 8'hFF;
   localparam logic [7:0] REPLY_OK_MAX     = 8'h01;
   localparam logic [2:0] FRAME_LAST       = 3'd5;
   localparam logic [3:0] POLL_TRIES_RESET = 4'd10;

   typedef struct packed {
      logic        mode;
      logic [5:0]  cmd_index;
      logic        app_command;
      logic [31:0] argument;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic [7:0] response;
      logic       timed_out;
   } rsp_type;

   typedef struct packed {
      phase_type phase;
      logic      in_prefix;
   } status_type;

   // One byte of a command frame: start bits with index, argument MSB first, CRC.
   function automatic logic [7:0] frame_byte(logic [2:0] pos, logic [5:0] idx,
                                             logic [31:0] arg);
      logic [7:0] b;
      case (pos)
         3'd0: b = START_BITS | {2'b00, idx};
         3'd1: b = arg[31:24];
         3'd2: b = arg[23:16];
         3'd3: b = arg[15:8];
         3'd4: b = arg[7:0];
         default: begin
            if (idx == CMD0_INDEX) b = CRC_CMD0;
            else if (idx == CMD8_INDEX) b = CRC_CMD8;
            else b = CRC_OTHER;
         end
      endcase
      return b;
   endfunction

endpackage

/* rtl/sdspi_in.sv */
// Input register that holds one request until the sequencer consumes it.
`timescale 1ns / 1ps

module sdspi_in (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sdspi_pkg::req_type req_data,
   input  logic               fire,
   output logic               held_valid,
   output sdspi_pkg::req_type held_data
);

   logic               valid_ff;
   logic               valid_in;
   sdspi_pkg::req_type data_ff;
   logic               accept;

   assign req_stall = valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) valid_in = 1'b1;
      else if (fire) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) data_ff <= req_data;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

/* rtl/sdspi_seq.sv */
// Command sequencer: per-request state update and next transmit byte or final reply.
`timescale 1ns / 1ps

module sdspi_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sdspi_pkg::req_type    req,
   input  logic [3:0]            poll_tries,
   output logic                  rsp_load,
   output sdspi_pkg::rsp_type    rsp,
   output sdspi_pkg::status_type status
);

   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           pos_ff, pos_in;
   logic [3:0]           tries_ff, tries_in;
   logic [5:0]           index_ff, index_in;
   logic [31:0]          arg_ff, arg_in;
   logic                 prefix_ff, prefix_in;
   logic [7:0]           preply_ff, preply_in;
   logic                 ptmo_ff, ptmo_in;

   logic [5:0]           eff_idx;
   logic [31:0]          eff_arg;
   logic [3:0]           tries_dec;
   logic                 poll_end;
   logic [2:0]           pos_next;

   // During the CMD55 prefix the frame carries index 55 and a zero argument.
   assign eff_idx   = prefix_ff ? sdspi_pkg::APP_PREFIX_INDEX : index_ff;
   assign eff_arg   = prefix_ff ? 32'd0 : arg_ff;
   assign tries_dec = tries_ff - 4'd1;
   assign poll_end  = !req.rx_byte[7] || (tries_dec == 4'd0);
   assign pos_next  = pos_ff + 3'd1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tries_in  = tries_ff;
      index_in  = index_ff;
      arg_in    = arg_ff;
      prefix_in = prefix_ff;
      preply_in = preply_ff;
      ptmo_in   = ptmo_ff;
      rsp_load  = 1'b0;
      rsp       = '0;
      if (fire) begin
         rsp_load = 1'b1;
         rsp.kind = sdspi_pkg::KIND_TX;
         if (req.mode == sdspi_pkg::MODE_START) begin
            index_in  = req.cmd_index;
            arg_in    = req.argument;
            preply_in = 8'd0;
            ptmo_in   = 1'b0;
            pos_in    = 3'd0;
            if (req.app_command) begin
               prefix_in   = 1'b1;
               phase_in    = sdspi_pkg::PH_PRE_FF;
               rsp.tx_byte = sdspi_pkg::FILL_BYTE;
            end else begin
               prefix_in   = 1'b0;
               phase_in    = sdspi_pkg::PH_FRAME;
               rsp.tx_byte = sdspi_pkg::frame_byte(3'd0, req.cmd_index, req.argument);
            end
         end else begin
            case (phase_ff)
               sdspi_pkg::PH_PRE_FF: begin
                  phase_in    = sdspi_pkg::PH_FRAME;
                  pos_in      = 3'd0;
                  rsp.tx_byte = sdspi_pkg::frame_byte(3'd0, eff_idx, eff_arg);
               end
               sdspi_pkg::PH_FRAME: begin
                  if (pos_ff < sdspi_pkg::FRAME_LAST) begin
                     pos_in      = pos_next;
                     rsp.tx_byte = sdspi_pkg::frame_byte(pos_next, eff_idx, eff_arg);
                  end else begin
                     phase_in    = sdspi_pkg::PH_POLL;
                     tries_in    = poll_tries;
                     rsp.tx_byte = sdspi_pkg::FILL_BYTE;
                  end
               end
               sdspi_pkg::PH_POLL: begin
                  if (req.rx_byte[7]) tries_in = tries_dec;
                  if (!poll_end) begin
                     rsp.tx_byte = sdspi_pkg::FILL_BYTE;
                  end else if (prefix_ff) begin
                     // Hold the CMD55 reply over the trailing fill byte.
                     preply_in   = req.rx_byte;
                     ptmo_in     = req.rx_byte[7];
                     phase_in    = sdspi_pkg::PH_POST_FF;
                     rsp.tx_byte = sdspi_pkg::FILL_BYTE;
                  end else begin
                     phase_in      = sdspi_pkg::PH_IDLE;
                     rsp.kind      = sdspi_pkg::KIND_DONE;
                     rsp.response  = req.rx_byte;
                     rsp.timed_out = req.rx_byte[7];
                  end
               end
               sdspi_pkg::PH_POST_FF: begin
                  prefix_in = 1'b0;
                  if (preply_ff > sdspi_pkg::REPLY_OK_MAX) begin
                     phase_in      = sdspi_pkg::PH_IDLE;
                     rsp.kind      = sdspi_pkg::KIND_DONE;
                     rsp.response  = preply_ff;
                     rsp.timed_out = ptmo_ff;
                  end else begin
                     phase_in    = sdspi_pkg::PH_FRAME;
                     pos_in      = 3'd0;
                     rsp.tx_byte = sdspi_pkg::frame_byte(3'd0, index_ff, arg_ff);
                  end
               end
               default: begin
                  phase_in = sdspi_pkg::PH_IDLE;
                  rsp_load = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sdspi_pkg::PH_IDLE;
         pos_ff    <= 3'd0;
         tries_ff  <= 4'd0;
         prefix_ff <= 1'b0;
         preply_ff <= 8'd0;
         ptmo_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tries_ff  <= tries_in;
         prefix_ff <= prefix_in;
         preply_ff <= preply_in;
         ptmo_ff   <= ptmo_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      arg_ff   <= arg_in;
   end

   assign status.phase     = phase_ff;
   assign status.in_prefix = prefix_ff;

endmodule

/* rtl/sdspi_out.sv */
// Result register that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module sdspi_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sdspi_pkg::rsp_type rsp_in,
   output logic               ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sdspi_pkg::rsp_type rsp_out
);

   logic               valid_ff;
   logic               valid_in;
   sdspi_pkg::rsp_type data_ff;

   // The register can take a new result when empty or when its current one leaves.
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (!rsp_stall) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

/* rtl/sd_spi_command_engine.sv */
// Top level of the SD SPI-mode command engine with R1 reply polling.
// Usage: a request with req_mode 0 starts a command (index, app flag, argument);
// each request with req_mode 1 reports the byte clocked in from the card during
// the last exchange. Every request except a received byte while idle yields one
// result: either the next byte to shift out (rsp_kind 0) or the final R1 reply
// with its timeout flag (rsp_kind 1). A start request aborts any command in
// progress. csr_poll_tries sets the number of 0xFF polls; csr_ready is always high
// and writes belong only to idle periods.
// A request accepted into the input register is processed once the result register
// can take a result; processing loads its result into the output register and
// raises rsp_valid.
// Throughput: one request per cycle while rsp_stall is low, set by the single input
// register feeding the sequencer logic and the single result register.
// Reset (synchronous, active high) empties both registers, returns the sequencer
// to idle and sets poll tries to 10. While rsp_stall is high the result register
// holds; the input register then fills and req_stall rises until a slot frees.
`timescale 1ns / 1ps

module sd_spi_command_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [5:0]  req_cmd_index,
   input  logic        req_app_command,
   input  logic [31:0] req_argument,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_response,
   output logic        rsp_timed_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_poll_tries
);

   sdspi_pkg::req_type    req_data;
   sdspi_pkg::req_type    held_data;
   sdspi_pkg::rsp_type    seq_rsp;
   sdspi_pkg::rsp_type    out_rsp;
   sdspi_pkg::status_type seq_status;
   logic                  held_valid;
   logic                  out_ready;
   logic                  fire;
   logic                  rsp_load;
   logic [3:0]            poll_tries_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) poll_tries_ff <= sdspi_pkg::POLL_TRIES_RESET;
      else if (csr_valid && csr_ready) poll_tries_ff <= csr_poll_tries;
   end

   assign req_data.mode        = req_mode;
   assign req_data.cmd_index   = req_cmd_index;
   assign req_data.app_command = req_app_command;
   assign req_data.argument    = req_argument;
   assign req_data.rx_byte     = req_rx_byte;

   assign fire = held_valid && out_ready;

   sdspi_in u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .fire       (fire),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   sdspi_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .req        (held_data),
      .poll_tries (poll_tries_ff),
      .rsp_load   (rsp_load),
      .rsp        (seq_rsp),
      .status     (seq_status)
   );

   sdspi_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .rsp_in    (seq_rsp),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (out_rsp)
   );

   assign rsp_kind      = out_rsp.kind;
   assign rsp_tx_byte   = out_rsp.tx_byte;
   assign rsp_response  = out_rsp.response;
   assign rsp_timed_out = out_rsp.timed_out;

`ifndef SYNTHESIS
   // A finished command always leaves the sequencer idle.
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && seq_rsp.kind == sdspi_pkg::KIND_DONE)
      |=> (seq_status.phase == sdspi_pkg::PH_IDLE))
      else $error("sequencer not idle after a finished command");

   // Input back-pressure only arises from a held request behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (held_valid && rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // Unused result fields are zero.
   a_tx_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == sdspi_pkg::KIND_TX)
      |-> (rsp_response == 8'd0 && !rsp_timed_out))
      else $error("transmit result carries reply fields");

   // The prefix flag is never set while idle after a finished command.
   a_prefix_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && seq_rsp.kind == sdspi_pkg::KIND_DONE && !seq_status.in_prefix)
      |=> !seq_status.in_prefix)
      else $error("prefix flag set after a finished command");
`endif

endmodule
